// ----- rtl/plh_pkg.sv -----
`default_nettype none

package plh_pkg;

   localparam int ROWS         = 6;
   localparam int LETTERS      = 26;
   localparam int COUNT_BITS   = 40;

   localparam int OP_BITS      = 1;
   localparam int LETTER_BITS  = 5;
   localparam int WEIGHT_BITS  = 24;
   localparam int ROW_BITS     = 3;

   localparam int ADDR_BITS    = $clog2(LETTERS);
   localparam int ROW_IDX_BITS = $clog2(ROWS);
   localparam int LAST_POS     = ROWS - 2;
   localparam int POS_BITS     = $clog2(LAST_POS + 1);

   localparam int CMD_DEPTH    = 4;
   localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);

   localparam int RSP_DEPTH    = 2;
   localparam int RSP_PTR_BITS = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS = $clog2(RSP_DEPTH + 1);

   localparam logic [OP_BITS-1:0] OP_ADD  = 1'b0;
   localparam logic [OP_BITS-1:0] OP_DUMP = 1'b1;

   typedef struct packed {
      logic                    is_dump;
      logic [ADDR_BITS-1:0]    letter;
      logic [WEIGHT_BITS-1:0]  weight;
      logic [ROWS-1:0]         rows;     // banks to bump on an add
      logic [ROW_IDX_BITS-1:0] row;      // row to dump
   } cmd_type;

   typedef struct packed {
      logic [LETTER_BITS-1:0] letter;
      logic [COUNT_BITS-1:0]  count;
      logic [COUNT_BITS-1:0]  total;
      logic                   last;
   } rsp_type;

   function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0]  acc,
                                                     input logic [WEIGHT_BITS-1:0] w);
      logic [COUNT_BITS:0] sum;
      sum = {1'b0, acc} + (COUNT_BITS + 1)'(w);
      return sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/positional_letter_histogram.sv -----
// Channel   Handshake      Word
// req       push / full    req_operation, req_letter, req_weight, req_end_of_word, req_row_select
// rsp       pop / empty    rsp_out_letter, rsp_letter_count, rsp_row_total, rsp_last_of_dump
//
// In the back end an add is one bank read, then a write to every row bank it
// touches (up to three, one RAM per row, so they go in parallel).
// A dump reads each letter in turn and pushes its result, waiting while the result queue is full.
// A four-word command queue separates the front from the back; results leave through a
// two-word queue, and a stalled pop holds the dump without losing words.
// Reset clears valid bits and row totals directly; there is no clearing pass.
`default_nettype none

module positional_letter_histogram (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                push,
   output      logic                                full,
   input  wire logic [plh_pkg::OP_BITS-1:0]         req_operation,
   input  wire logic [plh_pkg::LETTER_BITS-1:0]     req_letter,
   input  wire logic [plh_pkg::WEIGHT_BITS-1:0]     req_weight,
   input  wire logic                                req_end_of_word,
   input  wire logic [plh_pkg::ROW_BITS-1:0]        req_row_select,
   output      logic                                empty,
   input  wire logic                                pop,
   output      logic [plh_pkg::LETTER_BITS-1:0]     rsp_out_letter,
   output      logic [plh_pkg::COUNT_BITS-1:0]      rsp_letter_count,
   output      logic [plh_pkg::COUNT_BITS-1:0]      rsp_row_total,
   output      logic                                rsp_last_of_dump
);

   logic             accept;
   logic             cmd_push;
   plh_pkg::cmd_type cmd_new;
   logic             cmd_valid;
   plh_pkg::cmd_type cmd_head;
   logic             cmd_pop;
   plh_pkg::rsp_type rsp_word;

   assign accept = push && !full;

   plh_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .operation   (req_operation),
      .letter      (req_letter),
      .weight      (req_weight),
      .end_of_word (req_end_of_word),
      .row_select  (req_row_select),
      .cmd_push    (cmd_push),
      .cmd         (cmd_new)
   );

   plh_cmd_queue u_cmd_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (cmd_push),
      .wr_cmd (cmd_new),
      .full   (full),
      .valid  (cmd_valid),
      .head   (cmd_head),
      .pop    (cmd_pop)
   );

   plh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_empty (empty),
      .rsp_head  (rsp_word),
      .rsp_pop   (pop)
   );

   assign rsp_out_letter   = rsp_word.letter;
   assign rsp_letter_count = rsp_word.count;
   assign rsp_row_total    = rsp_word.total;
   assign rsp_last_of_dump = rsp_word.last;

   a_pop_needs_cmd : assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from an empty queue");

   a_reset_clears : assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   a_last_letter : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_last_of_dump) |->
         (rsp_out_letter == plh_pkg::LETTER_BITS'(plh_pkg::LETTERS - 1)))
      else $error("end of dump flagged on the wrong letter");

   a_total_bounds_count : assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_letter_count <= rsp_row_total))
      else $error("letter count exceeds its row total");

endmodule

`default_nettype wire

// ----- rtl/plh_ram.sv -----
`default_nettype none

module plh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/plh_front.sv -----
`default_nettype none

module plh_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             accept,
   input  wire logic [plh_pkg::OP_BITS-1:0]      operation,
   input  wire logic [plh_pkg::LETTER_BITS-1:0]  letter,
   input  wire logic [plh_pkg::WEIGHT_BITS-1:0]  weight,
   input  wire logic                             end_of_word,
   input  wire logic [plh_pkg::ROW_BITS-1:0]     row_select,
   output      logic                             cmd_push,
   output      plh_pkg::cmd_type                 cmd
);

   logic [plh_pkg::POS_BITS-1:0] pos_ff, pos_in;
   logic                         is_add;
   logic                         letter_ok;
   logic                         row_ok;

   assign is_add    = (operation == plh_pkg::OP_ADD);
   assign letter_ok = (letter < plh_pkg::LETTER_BITS'(plh_pkg::LETTERS));
   assign row_ok    = (row_select < plh_pkg::ROW_BITS'(plh_pkg::ROWS));

   always_comb begin
      cmd.is_dump = !is_add;
      cmd.letter  = letter[plh_pkg::ADDR_BITS-1:0];
      cmd.weight  = weight;
      cmd.row     = row_select[plh_pkg::ROW_IDX_BITS-1:0];
      cmd.rows    = '0;
      cmd.rows[0] = 1'b1;
      for (int r = 1; r < plh_pkg::ROWS - 1; r++) begin
         cmd.rows[r] = (pos_ff == plh_pkg::POS_BITS'(r - 1));
      end
      cmd.rows[plh_pkg::ROWS-1] = end_of_word;
   end

   // bad letters still move the word position but queue nothing; dumps of rows past the last queue nothing
   assign cmd_push = accept && (is_add ? letter_ok : row_ok);

   always_comb begin
      pos_in = pos_ff;
      if (accept && is_add) begin
         if (end_of_word) begin
            pos_in = '0;
         end else if (pos_ff < plh_pkg::POS_BITS'(plh_pkg::LAST_POS)) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/plh_cmd_queue.sv -----
`default_nettype none

module plh_cmd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire plh_pkg::cmd_type wr_cmd,
   output      logic             full,
   output      logic             valid,
   output      plh_pkg::cmd_type head,
   input  wire logic             pop
);

   plh_pkg::cmd_type                  entry_ff [plh_pkg::CMD_DEPTH];
   logic [plh_pkg::CMD_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [plh_pkg::CMD_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [plh_pkg::CMD_CNT_BITS-1:0]  count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign full    = (count_ff == plh_pkg::CMD_CNT_BITS'(plh_pkg::CMD_DEPTH));
   assign valid   = (count_ff != '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/plh_back.sv -----
`default_nettype none

module plh_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  wire plh_pkg::cmd_type cmd_head,
   output      logic             cmd_pop,
   output      logic             rsp_empty,
   output      plh_pkg::rsp_type rsp_head,
   input  wire logic             rsp_pop
);

   localparam logic [1:0] ST_IDLE     = 2'd0;
   localparam logic [1:0] ST_UPD_WR   = 2'd1;
   localparam logic [1:0] ST_DMP_RD   = 2'd2;
   localparam logic [1:0] ST_DMP_PUSH = 2'd3;

   logic [1:0]                       state_ff, state_in;
   plh_pkg::cmd_type                 cmd_ff, cmd_in;
   logic [plh_pkg::ADDR_BITS-1:0]    idx_ff, idx_in;
   logic [plh_pkg::LETTERS-1:0]      valid_ff [plh_pkg::ROWS];
   logic [plh_pkg::LETTERS-1:0]      valid_in [plh_pkg::ROWS];
   logic [plh_pkg::COUNT_BITS-1:0]   row_sum_ff [plh_pkg::ROWS];
   logic [plh_pkg::COUNT_BITS-1:0]   row_sum_in [plh_pkg::ROWS];

   logic [plh_pkg::ADDR_BITS-1:0]    rd_addr;
   logic [plh_pkg::ADDR_BITS-1:0]    cur_addr;
   logic                             rd_en;
   logic [plh_pkg::ROWS-1:0]         bank_we;
   logic [plh_pkg::COUNT_BITS-1:0]   bank_rd  [plh_pkg::ROWS];
   logic [plh_pkg::COUNT_BITS-1:0]   bank_val [plh_pkg::ROWS];
   logic [plh_pkg::COUNT_BITS-1:0]   bank_wd  [plh_pkg::ROWS];

   plh_pkg::rsp_type                 rq_ff [plh_pkg::RSP_DEPTH];
   logic [plh_pkg::RSP_PTR_BITS-1:0] rq_wr_ff, rq_wr_in;
   logic [plh_pkg::RSP_PTR_BITS-1:0] rq_rd_ff, rq_rd_in;
   logic [plh_pkg::RSP_CNT_BITS-1:0] rq_cnt_ff, rq_cnt_in;
   logic                             rq_room;
   logic                             rq_push;
   logic                             rq_pop;
   plh_pkg::rsp_type                 rq_word;

   assign rq_room   = (rq_cnt_ff != plh_pkg::RSP_CNT_BITS'(plh_pkg::RSP_DEPTH));
   assign rsp_empty = (rq_cnt_ff == '0);
   assign rsp_head  = rq_ff[rq_rd_ff];
   assign rq_pop    = rsp_pop && !rsp_empty;
   assign rq_push   = (state_ff == ST_DMP_PUSH);

   assign cmd_pop  = (state_ff == ST_IDLE) && cmd_valid;
   assign rd_addr  = (state_ff == ST_IDLE) ? cmd_head.letter : idx_ff;
   assign rd_en    = (state_ff == ST_IDLE) || (state_ff == ST_DMP_RD);
   // address whose read data is on the bank outputs this cycle
   assign cur_addr = (state_ff == ST_UPD_WR) ? cmd_ff.letter : idx_ff;

   genvar r;
   for (r = 0; r < plh_pkg::ROWS; r++) begin : g_bank
      plh_ram #(
         .WIDTH(plh_pkg::COUNT_BITS),
         .DEPTH(plh_pkg::LETTERS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (bank_we[r]),
         .wr_addr (cmd_ff.letter),
         .wr_data (bank_wd[r]),
         .rd_en   (rd_en),
         .rd_addr (rd_addr),
         .rd_data (bank_rd[r])
      );

      // never-written entries read as zero
      assign bank_val[r] = valid_ff[r][cur_addr] ? bank_rd[r] : '0;
      assign bank_wd[r]  = plh_pkg::sat_add(bank_val[r], cmd_ff.weight);
      assign bank_we[r]  = (state_ff == ST_UPD_WR) && cmd_ff.rows[r];
   end

   always_comb begin
      for (int i = 0; i < plh_pkg::ROWS; i++) begin
         valid_in[i]   = valid_ff[i];
         row_sum_in[i] = row_sum_ff[i];
         if (bank_we[i]) begin
            valid_in[i][cmd_ff.letter] = 1'b1;
            row_sum_in[i] = plh_pkg::sat_add(row_sum_ff[i], cmd_ff.weight);
         end
      end
   end

   always_comb begin
      rq_word.letter = plh_pkg::LETTER_BITS'(idx_ff);
      rq_word.count  = bank_val[cmd_ff.row];
      rq_word.total  = row_sum_ff[cmd_ff.row];
      rq_word.last   = (idx_ff == plh_pkg::ADDR_BITS'(plh_pkg::LETTERS - 1));
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in   = cmd_head;
               idx_in   = '0;
               state_in = cmd_head.is_dump ? ST_DMP_RD : ST_UPD_WR;
            end
         end
         ST_UPD_WR: begin
            state_in = ST_IDLE;
         end
         ST_DMP_RD: begin
            if (rq_room) begin
               state_in = ST_DMP_PUSH;
            end
         end
         ST_DMP_PUSH: begin
            if (rq_word.last) begin
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_DMP_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rq_wr_in  = rq_push ? rq_wr_ff + 1'b1 : rq_wr_ff;
      rq_rd_in  = rq_pop  ? rq_rd_ff + 1'b1 : rq_rd_ff;
      rq_cnt_in = rq_cnt_ff;
      if (rq_push && !rq_pop) begin
         rq_cnt_in = rq_cnt_ff + 1'b1;
      end else if (rq_pop && !rq_push) begin
         rq_cnt_in = rq_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rq_wr_ff  <= '0;
         rq_rd_ff  <= '0;
         rq_cnt_ff <= '0;
         for (int i = 0; i < plh_pkg::ROWS; i++) begin
            valid_ff[i]   <= '0;
            row_sum_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         rq_wr_ff  <= rq_wr_in;
         rq_rd_ff  <= rq_rd_in;
         rq_cnt_ff <= rq_cnt_in;
         for (int i = 0; i < plh_pkg::ROWS; i++) begin
            valid_ff[i]   <= valid_in[i];
            row_sum_ff[i] <= row_sum_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      if (rq_push) begin
         rq_ff[rq_wr_ff] <= rq_word;
      end
   end

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import plh_pkg::*;

   localparam logic [ROW_BITS-1:0]    ROW_ANY    = 3'd0;
   localparam logic [ROW_BITS-1:0]    ROW_FIRST  = 3'd1;
   localparam logic [ROW_BITS-1:0]    ROW_SECOND = 3'd2;
   localparam logic [ROW_BITS-1:0]    ROW_THIRD  = 3'd3;
   localparam logic [ROW_BITS-1:0]    ROW_FOURTH = 3'd4;
   localparam logic [ROW_BITS-1:0]    ROW_LAST   = ROW_BITS'(ROWS - 1);
   localparam logic [ROW_BITS-1:0]    ROW_PAST   = ROW_BITS'(ROWS);
   localparam logic [ROW_BITS-1:0]    ROW_VOID   = '1;
   localparam logic [LETTER_BITS-1:0] LETTER_Z   = LETTER_BITS'(LETTERS - 1);
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = '1;
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;
   localparam int CYCLE_LIMIT = 100_000;

   typedef struct packed {
      logic [OP_BITS-1:0]     op;
      logic [LETTER_BITS-1:0] letter;
      logic [WEIGHT_BITS-1:0] weight;
      logic                   eow;
      logic [ROW_BITS-1:0]    sel;
      logic                   typed;        // dump expectation given in the table
      logic [COUNT_BITS-1:0]  typed_total;  // count at .letter and row total
   } stim_row_type;

   typedef struct packed {
      logic [LETTER_BITS-1:0] letter;
      logic [COUNT_BITS-1:0]  count;
      logic [COUNT_BITS-1:0]  total;
      logic                   last;
   } dump_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   push = 1'b0;
   logic                   full;
   logic [OP_BITS-1:0]     req_operation = OP_ADD;
   logic [LETTER_BITS-1:0] req_letter = '0;
   logic [WEIGHT_BITS-1:0] req_weight = '0;
   logic                   req_end_of_word = 1'b0;
   logic [ROW_BITS-1:0]    req_row_select = '0;
   logic                   empty;
   logic                   pop = 1'b0;
   logic [LETTER_BITS-1:0] rsp_out_letter;
   logic [COUNT_BITS-1:0]  rsp_letter_count;
   logic [COUNT_BITS-1:0]  rsp_row_total;
   logic                   rsp_last_of_dump;

   logic [COUNT_BITS-1:0] hist_counts [ROWS][LETTERS] = '{default: '0};
   logic [COUNT_BITS-1:0] hist_totals [ROWS] = '{default: '0};
   int                    word_pos = 0;
   dump_word_type         dump_words_due [$];

   int errors = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int read_stall_pct = 0;

   stim_row_type directed_rows [25] = '{
      '{OP_DUMP, 5'd0, 24'd0, 1'b0, ROW_ANY, 1'b1, 40'd0},     // all clear after reset
      '{OP_DUMP, 5'd0, 24'd0, 1'b0, ROW_VOID, 1'b1, 40'd0},    // no such row: silent
      '{OP_DUMP, 5'd0, 24'd0, 1'b0, ROW_PAST, 1'b1, 40'd0},
      '{OP_ADD, LETTER_Z, WEIGHT_MAX, 1'b1, ROW_VOID, 1'b0, 40'd0},
      '{OP_DUMP, LETTER_Z, 24'd0, 1'b0, ROW_LAST, 1'b1, 40'hFF_FFFF},
      '{OP_DUMP, LETTER_Z, 24'd0, 1'b0, ROW_FIRST, 1'b1, 40'hFF_FFFF},
      '{OP_DUMP, 5'd0, 24'd0, 1'b0, ROW_SECOND, 1'b1, 40'd0},
      // seven-letter word, zero weight on the first letter
      '{OP_ADD, 5'd0, 24'd0, 1'b0, ROW_ANY, 1'b0, 40'd0},
      '{OP_ADD, 5'd1, 24'd3, 1'b0, ROW_ANY, 1'b0, 40'd0},
      '{OP_ADD, 5'd2, 24'd2, 1'b0, ROW_ANY, 1'b0, 40'd0},
      '{OP_ADD, 5'd3, 24'd3, 1'b0, ROW_ANY, 1'b0, 40'd0},
      '{OP_ADD, 5'd4, 24'd4, 1'b0, ROW_ANY, 1'b0, 40'd0},
      '{OP_ADD, 5'd5, 24'd5, 1'b0, ROW_ANY, 1'b0, 40'd0},
      '{OP_ADD, 5'd6, 24'd6, 1'b1, ROW_ANY, 1'b0, 40'd0},
      // letters off the alphabet still move and end the word
      '{OP_ADD, 5'd31, WEIGHT_MAX, 1'b0, ROW_ANY, 1'b0, 40'd0},
      '{OP_ADD, 5'd26, WEIGHT_MAX, 1'b1, ROW_ANY, 1'b0, 40'd0},
      '{OP_ADD, 5'd1, 24'd5, 1'b0, ROW_ANY, 1'b0, 40'd0},
      '{OP_DUMP, 5'd0, 24'd0, 1'b0, ROW_THIRD, 1'b0, 40'd0},
      '{OP_DUMP, 5'd0, 24'd0, 1'b0, ROW_FOURTH, 1'b0, 40'd0},
      '{OP_DUMP, 5'd0, 24'd0, 1'b0, ROW_ANY, 1'b0, 40'd0},
      // dump mid-word with every ignored field set: position must hold
      '{OP_DUMP, 5'd31, WEIGHT_MAX, 1'b1, ROW_LAST, 1'b0, 40'd0},
      '{OP_ADD, 5'd2, 24'd7, 1'b1, ROW_VOID, 1'b0, 40'd0},
      '{OP_DUMP, 5'd0, 24'd0, 1'b0, ROW_SECOND, 1'b0, 40'd0},
      '{OP_DUMP, 5'd0, 24'd0, 1'b0, ROW_FIRST, 1'b0, 40'd0},
      '{OP_DUMP, 5'd0, 24'd0, 1'b0, ROW_LAST, 1'b0, 40'd0}
   };

   positional_letter_histogram u_top (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_operation    (req_operation),
      .req_letter       (req_letter),
      .req_weight       (req_weight),
      .req_end_of_word  (req_end_of_word),
      .req_row_select   (req_row_select),
      .empty            (empty),
      .pop              (pop),
      .rsp_out_letter   (rsp_out_letter),
      .rsp_letter_count (rsp_letter_count),
      .rsp_row_total    (rsp_row_total),
      .rsp_last_of_dump (rsp_last_of_dump)
   );

   always #2 clock = ~clock;

   function automatic logic [COUNT_BITS-1:0] capped_sum(input logic [COUNT_BITS-1:0]  acc,
                                                        input logic [WEIGHT_BITS-1:0] w);
      logic [COUNT_BITS-1:0] room;
      room = COUNT_MAX - acc;
      return (COUNT_BITS'(w) > room) ? COUNT_MAX : acc + COUNT_BITS'(w);
   endfunction

   function automatic logic [WEIGHT_BITS-1:0] pick_weight();
      int r;
      r = $urandom_range(9);
      if (r == 0) return '0;
      if (r == 1) return WEIGHT_MAX;
      if (r < 5) return WEIGHT_BITS'($urandom_range(255));
      return WEIGHT_BITS'($urandom);
   endfunction

   task automatic credit(input int row, input int letter, input logic [WEIGHT_BITS-1:0] w);
      hist_counts[row][letter] = capped_sum(hist_counts[row][letter], w);
      hist_totals[row] = capped_sum(hist_totals[row], w);
   endtask

   task automatic histogram_update(input stim_row_type it);
      dump_word_type e;
      if (it.op == OP_ADD) begin
         if (it.letter < LETTERS) begin
            credit(ROW_ANY, it.letter, it.weight);
            if (word_pos < LAST_POS) credit(word_pos + 1, it.letter, it.weight);
            if (it.eow) credit(ROW_LAST, it.letter, it.weight);
         end
         if (it.eow) word_pos = 0;
         else if (word_pos < LAST_POS) word_pos++;
      end else if (it.sel < ROWS) begin
         for (int j = 0; j < LETTERS; j++) begin
            e.letter = LETTER_BITS'(j);
            e.last   = (j == LETTERS - 1);
            if (it.typed) begin
               e.count = (j == it.letter) ? it.typed_total : '0;
               e.total = it.typed_total;
            end else begin
               e.count = hist_counts[it.sel][j];
               e.total = hist_totals[it.sel];
            end
            dump_words_due.push_back(e);
         end
      end
   endtask

   task automatic put_word(input stim_row_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push            <= 1'b1;
      req_operation   <= it.op;
      req_letter      <= it.letter;
      req_weight      <= it.weight;
      req_end_of_word <= it.eow;
      req_row_select  <= it.sel;
      @(posedge clock);
      while (full) @(posedge clock);
      histogram_update(it);
   endtask

   // drop push on the accepting edge, then hold off until every dump word is back
   task automatic settle();
      push <= 1'b0;
      @(posedge clock);
      while (dump_words_due.size() != 0) @(posedge clock);
   endtask

   task automatic random_phase(input int idle, input int stall, input int quota);
      stim_row_type           it;
      int                     sent;
      int                     len;
      int                     pick;
      logic [WEIGHT_BITS-1:0] w;
      send_idle_pct  = idle;
      read_stall_pct = stall;
      sent = 0;
      while (sent < quota) begin
         it   = '0;
         pick = $urandom_range(99);
         if (pick < 65) begin
            // whole word, one weight, occasional letter off the alphabet
            len = $urandom_range(1, 7);
            w   = pick_weight();
            for (int k = 0; k < len; k++) begin
               it.op     = OP_ADD;
               it.letter = ($urandom_range(19) == 0) ? LETTER_BITS'($urandom_range(31))
                                                     : LETTER_BITS'($urandom_range(LETTERS - 1));
               it.weight = w;
               it.eow    = (k == len - 1);
               it.sel    = ROW_BITS'($urandom);
               put_word(it);
            end
            sent += len;
         end else begin
            it.op     = (pick < 75) ? OP_ADD : OP_DUMP;
            it.letter = LETTER_BITS'($urandom);
            it.weight = pick_weight();
            it.eow    = $urandom_range(1);
            it.sel    = ($urandom_range(4) == 0) ? ROW_BITS'($urandom)
                                                 : ROW_BITS'($urandom_range(ROWS - 1));
            put_word(it);
            sent++;
         end
      end
      settle();
   endtask

   always @(posedge clock) begin
      dump_word_type e;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (dump_words_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected word, letter %0d count %h total %h", $time,
                        rsp_out_letter, rsp_letter_count, rsp_row_total);
            end else begin
               e = dump_words_due.pop_front();
               if (rsp_out_letter !== e.letter) begin
                  errors++;
                  $display("%0t: out_letter expected %0d actual %0d", $time,
                           e.letter, rsp_out_letter);
               end
               if (rsp_letter_count !== e.count) begin
                  errors++;
                  $display("%0t: letter_count (letter %0d) expected %h actual %h", $time,
                           e.letter, e.count, rsp_letter_count);
               end
               if (rsp_row_total !== e.total) begin
                  errors++;
                  $display("%0t: row_total expected %h actual %h", $time,
                           e.total, rsp_row_total);
               end
               if (rsp_last_of_dump !== e.last) begin
                  errors++;
                  $display("%0t: last_of_dump expected %b actual %b", $time,
                           e.last, rsp_last_of_dump);
               end
            end
         end
         pop <= ($urandom_range(99) >= read_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) put_word(directed_rows[i]);
      settle();

      random_phase(0, 0, 33);
      random_phase(55, 0, 33);
      random_phase(0, 55, 33);
      random_phase(24, 24, 33);

      repeat (60) @(posedge clock);
      if (errors == 0 && dump_words_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- positional_letter_histogram.f -----
rtl/plh_pkg.sv
rtl/plh_ram.sv
rtl/plh_front.sv
rtl/plh_cmd_queue.sv
rtl/plh_back.sv
rtl/positional_letter_histogram.sv
dv/tb_top.sv
